@@ hw/rtl/lcsi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lcsi_pkg;

    localparam int NUM_COLUMNS_DEF     = 2;
    localparam int IDLE_COUNT_BITS_DEF = 16;
    localparam int MAX_COLUMNS         = 4;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int HEIGHT_W  = 24;

    localparam logic [CFG_W-1:0] STALL_TIMEOUT_RST = 16'd1000;
    localparam logic [CFG_W-1:0] GUARD_PULSES_RST  = 16'd0;
    localparam logic             GUARD_ENABLE_RST  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STALL_TIMEOUT = 2'd0,
        CFG_GUARD_PULSES  = 2'd1,
        CFG_GUARD_ENABLE  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIR_HALT = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DN   = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        ALARM_OFF   = 2'd0,
        ALARM_COLL  = 2'd1,
        ALARM_STUCK = 2'd2
    } t_alarm;

    typedef enum logic [1:0] {
        STOP_NONE      = 2'd0,
        STOP_IMMEDIATE = 2'd1,
        STOP_NORMAL    = 2'd2
    } t_stop;

    typedef enum logic [1:0] {
        BUZZ_NONE     = 2'd0,
        BUZZ_ALARM500 = 2'd1,
        BUZZ_ALARM1K  = 2'd2,
        BUZZ_OFF      = 2'd3
    } t_buzz;

    // input transaction, first field in the highest bits
    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_right;
        logic signed [HEIGHT_W-1:0] height_left;
        logic [1:0]                 column_pulse;
        logic [1:0]                 column_running;
        logic                       alarm_reset;
        logic [1:0]                 command_dir;
        logic                       command_valid;
        logic [3:0]                 collision_pins;
    } t_item;

    typedef struct packed {
        logic   descent_hold;
        logic   can_move_down;
        logic   can_move_up;
        t_buzz  buzzer_cmd;
        t_stop  stop_kind;
        logic   zero_heights;
        logic   lower_limit;
        logic   upper_limit;
        logic   stall_flag;
        t_alarm alarm_code;
        t_dir   drive_dir;
    } t_result;

    localparam int ITEM_W   = $bits(t_item);
    localparam int RESULT_W = $bits(t_result);
    localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    function automatic logic dir_blocked(t_dir dir, logic up, logic down);
        return ((dir == DIR_UP) && up) || ((dir == DIR_DN) && down);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lift_column_safety_interlock_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Safety interlock for a two-column lift, one transaction per millisecond tick.
// The block takes a transaction every clock unless m_axis_tready holds back a
// waiting result, and returns exactly one result per transaction: it passes the
// input register, then the whole tick update, then the result register. The result
// register lets a new transaction enter while a finished result waits for
// m_axis_tready. Configuration (stall timeout, descent guard height and enable,
// reset values 1000, 0 and 1) is written through i_cfg_we/i_cfg_idx/i_cfg_wdata
// and should only change while no transaction is in flight.
module lift_column_safety_interlock_top #(
    parameter int NUM_COLUMNS     = lcsi_pkg::NUM_COLUMNS_DEF,
    parameter int IDLE_COUNT_BITS = lcsi_pkg::IDLE_COUNT_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [lcsi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lcsi_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // collision_pins, command_valid, command_dir, alarm_reset, column_running,
    // column_pulse, height_left, height_right
    input  wire logic [lcsi_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // drive_dir, alarm_code, stall_flag, upper_limit, lower_limit, zero_heights,
    // stop_kind, buzzer_cmd, can_move_up, can_move_down, descent_hold
    output logic [lcsi_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

    logic              in_valid;
    lcsi_pkg::t_item   in_item;
    lcsi_pkg::t_result step_result;
    logic              step;
    logic              r_out_valid;
    lcsi_pkg::t_result r_result;

    assign step = in_valid && (!r_out_valid || m_axis_tready);

    lcsi_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_take  (step),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    lcsi_core #(
        .NUM_COLUMNS     (NUM_COLUMNS),
        .IDLE_COUNT_BITS (IDLE_COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_item      (in_item),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = lcsi_pkg::OUT_TDATA_W'(r_result);

    // a processed transaction always lands in the result register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed transaction lost");

    // the reported direction never points into an active limit
    a_no_drive_into_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            !((r_result.drive_dir == lcsi_pkg::DIR_UP && r_result.upper_limit) ||
              (r_result.drive_dir == lcsi_pkg::DIR_DN && r_result.lower_limit)))
        else $error("drive direction into active collision pin");

    // a height-zero strobe only comes with the lower limit active
    a_zero_needs_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.zero_heights) |-> r_result.lower_limit)
        else $error("height zero strobe without lower limit");

endmodule

`default_nettype wire

@@ hw/rtl/lcsi_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input register: holds one transaction until the core consumes it.
module lcsi_in_reg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [lcsi_pkg::IN_TDATA_W-1:0]     i_data,
    input  wire logic                                i_take,
    output logic                                     o_valid,
    output lcsi_pkg::t_item                          o_item
);

    logic            r_valid;
    lcsi_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= lcsi_pkg::t_item'(i_data[lcsi_pkg::ITEM_W-1:0]);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lcsi_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Interlock state, configuration registers and the per-tick update.
module lcsi_core #(
    parameter int NUM_COLUMNS     = lcsi_pkg::NUM_COLUMNS_DEF,
    parameter int IDLE_COUNT_BITS = lcsi_pkg::IDLE_COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lcsi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lcsi_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                              i_step,
    input  wire lcsi_pkg::t_item                   i_item,
    output lcsi_pkg::t_result                      o_result
);

    localparam int CMP_W = (IDLE_COUNT_BITS > lcsi_pkg::CFG_W) ? IDLE_COUNT_BITS
                                                               : lcsi_pkg::CFG_W;

    logic [lcsi_pkg::CFG_W-1:0] r_timeout;
    logic [lcsi_pkg::CFG_W-1:0] r_guard;
    logic                       r_guard_en;

    lcsi_pkg::t_dir   r_dir, n_dir;
    lcsi_pkg::t_alarm r_alarm, n_alarm;
    logic             r_stall, n_stall;
    logic             r_trip, n_trip;
    logic             r_prev_upper;
    logic             r_prev_lower;
    logic [IDLE_COUNT_BITS-1:0] r_idle [NUM_COLUMNS];
    logic [IDLE_COUNT_BITS-1:0] n_idle [NUM_COLUMNS];

    logic                          up, down;
    lcsi_pkg::t_dir                cmd_dir;
    lcsi_pkg::t_stop               stop_kind;
    lcsi_pkg::t_buzz               buzz;
    logic                          zero;
    logic                          stall_hit;
    logic                          cmd_ok;
    logic [lcsi_pkg::MAX_COLUMNS-1:0] run_ext, pulse_ext;
    logic signed [lcsi_pkg::HEIGHT_W-1:0] guard_s;

    assign up        = |i_item.collision_pins[1:0];
    assign down      = |i_item.collision_pins[3:2];
    assign run_ext   = lcsi_pkg::MAX_COLUMNS'(i_item.column_running);
    assign pulse_ext = lcsi_pkg::MAX_COLUMNS'(i_item.column_pulse);
    assign guard_s   = signed'(lcsi_pkg::HEIGHT_W'(r_guard));

    always_comb begin
        unique case (i_item.command_dir)
            lcsi_pkg::DIR_UP: cmd_dir = lcsi_pkg::DIR_UP;
            lcsi_pkg::DIR_DN: cmd_dir = lcsi_pkg::DIR_DN;
            default:          cmd_dir = lcsi_pkg::DIR_HALT;
        endcase
    end

    always_comb begin
        n_dir     = r_dir;
        n_alarm   = r_alarm;
        n_stall   = r_stall;
        n_trip    = r_trip;
        stop_kind = lcsi_pkg::STOP_NONE;
        buzz      = lcsi_pkg::BUZZ_NONE;
        stall_hit = 1'b0;

        if (i_item.alarm_reset && (r_alarm != lcsi_pkg::ALARM_OFF || r_stall)) begin
            n_alarm = lcsi_pkg::ALARM_OFF;
            n_stall = 1'b0;
            n_trip  = 1'b0;
            n_dir   = lcsi_pkg::DIR_HALT;
            buzz    = lcsi_pkg::BUZZ_OFF;
        end

        cmd_ok = !lcsi_pkg::dir_blocked(cmd_dir, up, down)
                 && (n_alarm == lcsi_pkg::ALARM_OFF || n_alarm == lcsi_pkg::ALARM_COLL)
                 && !n_stall;

        if (i_item.command_valid) begin
            if (cmd_dir == lcsi_pkg::DIR_HALT) begin
                n_dir = lcsi_pkg::DIR_HALT;
            end else if (cmd_ok) begin
                n_dir = cmd_dir;
            end else if (lcsi_pkg::dir_blocked(cmd_dir, up, down)) begin
                n_dir     = lcsi_pkg::DIR_HALT;
                n_alarm   = lcsi_pkg::ALARM_COLL;
                stop_kind = lcsi_pkg::STOP_IMMEDIATE;
                buzz      = lcsi_pkg::BUZZ_ALARM500;
            end
        end

        zero = down && !r_prev_lower;

        if (lcsi_pkg::dir_blocked(n_dir, up, down)) begin
            n_dir     = lcsi_pkg::DIR_HALT;
            n_alarm   = lcsi_pkg::ALARM_COLL;
            stop_kind = lcsi_pkg::STOP_IMMEDIATE;
            buzz      = lcsi_pkg::BUZZ_ALARM500;
        end
        if (n_alarm == lcsi_pkg::ALARM_COLL && !up && !down) begin
            n_alarm = lcsi_pkg::ALARM_OFF;
            buzz    = lcsi_pkg::BUZZ_OFF;
        end

        // saturating idle counters, cleared by an encoder pulse
        for (int i = 0; i < NUM_COLUMNS; i++) begin
            if (pulse_ext[i]) begin
                n_idle[i] = '0;
            end else if (r_idle[i] != '1) begin
                n_idle[i] = r_idle[i] + 1'b1;
            end else begin
                n_idle[i] = r_idle[i];
            end
            if (run_ext[i] && (CMP_W'(n_idle[i]) > CMP_W'(r_timeout))) begin
                stall_hit = 1'b1;
            end
        end

        if (n_alarm == lcsi_pkg::ALARM_OFF && stall_hit) begin
            n_dir     = lcsi_pkg::DIR_HALT;
            n_alarm   = lcsi_pkg::ALARM_STUCK;
            n_stall   = 1'b1;
            stop_kind = lcsi_pkg::STOP_NORMAL;
            buzz      = lcsi_pkg::BUZZ_ALARM1K;
        end

        if (r_guard_en && n_dir == lcsi_pkg::DIR_DN && !n_trip
            && (i_item.height_left <= guard_s || i_item.height_right <= guard_s)) begin
            n_dir     = lcsi_pkg::DIR_HALT;
            n_trip    = 1'b1;
            stop_kind = lcsi_pkg::STOP_NORMAL;
        end
    end

    always_comb begin
        o_result.drive_dir     = n_dir;
        o_result.alarm_code    = n_alarm;
        o_result.stall_flag    = n_stall;
        o_result.upper_limit   = up;
        o_result.lower_limit   = down;
        o_result.zero_heights  = zero;
        o_result.stop_kind     = stop_kind;
        o_result.buzzer_cmd    = buzz;
        o_result.can_move_up   = !up && !n_stall
            && (n_alarm == lcsi_pkg::ALARM_OFF || n_alarm == lcsi_pkg::ALARM_COLL);
        o_result.can_move_down = !down && !n_stall
            && (n_alarm == lcsi_pkg::ALARM_OFF || n_alarm == lcsi_pkg::ALARM_COLL);
        o_result.descent_hold  = n_trip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= lcsi_pkg::STALL_TIMEOUT_RST;
            r_guard    <= lcsi_pkg::GUARD_PULSES_RST;
            r_guard_en <= lcsi_pkg::GUARD_ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lcsi_pkg::CFG_STALL_TIMEOUT: r_timeout  <= i_cfg_wdata;
                lcsi_pkg::CFG_GUARD_PULSES:  r_guard    <= i_cfg_wdata;
                lcsi_pkg::CFG_GUARD_ENABLE:  r_guard_en <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir        <= lcsi_pkg::DIR_HALT;
            r_alarm      <= lcsi_pkg::ALARM_OFF;
            r_stall      <= 1'b0;
            r_trip       <= 1'b0;
            r_prev_upper <= 1'b0;
            r_prev_lower <= 1'b0;
            for (int i = 0; i < NUM_COLUMNS; i++) begin
                r_idle[i] <= '0;
            end
        end else if (i_step) begin
            r_dir        <= n_dir;
            r_alarm      <= n_alarm;
            r_stall      <= n_stall;
            r_trip       <= n_trip;
            r_prev_upper <= up;
            r_prev_lower <= down;
            for (int i = 0; i < NUM_COLUMNS; i++) begin
                r_idle[i] <= n_idle[i];
            end
        end
    end

    // a suspected stall keeps the drive stopped until the alarm is reset
    a_stall_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stall |-> (r_dir == lcsi_pkg::DIR_HALT))
        else $error("drive moving while stall flag is set");

    // the upper-limit history follows the processed transaction
    a_prev_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> (r_prev_upper == $past(up)))
        else $error("upper limit history not updated");

    // a stall alarm is only ever raised together with the stall flag
    a_stall_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_alarm == lcsi_pkg::ALARM_STUCK && r_alarm != lcsi_pkg::ALARM_STUCK)
        |-> n_stall)
        else $error("stall alarm raised without stall flag");

endmodule

`default_nettype wire
